// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL files; included by ws3d_front
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property checked on every rising clk edge outside reset
`define WS3D_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ws3d assertion failed");
// a in one cycle implies b in the next
`define WS3D_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) ((a) |=> (b))) \
    else $error("ws3d assertion failed");
`else
`define WS3D_ASSERT(lbl, prop)
`define WS3D_ASSERT_NEXT(lbl, a, b)
`endif
`endif

// ===== rtl/ws3d_pkg.sv =====
// Package: widths, register indexes, tap order and queue entry type
package ws3d_pkg;
  localparam int SAMPLE_W    = 16;
  localparam int SIZE_W      = 7;
  localparam int COEF_W      = 18;
  localparam int CFG_IDX_W   = 3;
  localparam int DEF_MAX_X   = 64;
  localparam int DEF_MAX_Y   = 64;
  localparam int DEF_MAX_Z   = 64;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_CEN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_NEAR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_FAR  = 3'd5;

  localparam logic [SIZE_W-1:0]  SIZE_RESET     = 7'd64;
  localparam logic signed [COEF_W-1:0] COEF_CEN_RESET  = 18'sd8192;
  localparam logic signed [COEF_W-1:0] COEF_NEAR_RESET = 18'sd21845;
  localparam logic signed [COEF_W-1:0] COEF_FAR_RESET  = -18'sd1365;

  // taps 0..11 come from window RAMs, tap 12 is the incoming sample
  localparam int N_RAM_TAPS = 12;
  localparam int N_TAPS     = 13;
  localparam int TAP_ZM2 = 0;
  localparam int TAP_ZM1 = 1;
  localparam int TAP_YM2 = 2;
  localparam int TAP_YM1 = 3;
  localparam int TAP_XM2 = 4;
  localparam int TAP_XM1 = 5;
  localparam int TAP_CEN = 6;
  localparam int TAP_XP1 = 7;
  localparam int TAP_XP2 = 8;
  localparam int TAP_YP1 = 9;
  localparam int TAP_YP2 = 10;
  localparam int TAP_ZP1 = 11;
  localparam int TAP_ZP2 = 12;

  typedef struct packed {
    logic [N_TAPS-1:0][SAMPLE_W-1:0] taps;
    logic [SAMPLE_W-1:0]             prev;
    logic                            bnd;
    logic                            eog;
  } ws3d_entry_t;

  function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v, int hi);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v < 7'd5) r = 7'd5;
    else if (int'(v) > hi) r = SIZE_W'(hi);
    return r;
  endfunction
endpackage

// ===== rtl/ws3d_ifs.sv =====
// Stream channel interfaces for grid points and results
interface ws3d_in_if;
  logic                        valid;
  logic                        ready;
  logic signed [15:0]          cur_sample;
  logic signed [15:0]          prev_sample;
  logic                        is_flush;
  modport source(output valid, cur_sample, prev_sample, is_flush, input ready);
  modport sink(input valid, cur_sample, prev_sample, is_flush, output ready);
endinterface

interface ws3d_out_if;
  logic                        valid;
  logic                        ready;
  logic signed [15:0]          next_sample;
  logic                        end_of_grid;
  modport source(output valid, next_sample, end_of_grid, input ready);
  modport sink(input valid, next_sample, end_of_grid, output ready);
endinterface

// ===== rtl/ws3d_ram.sv =====
// Generic simple dual-port RAM with registered read
module ws3d_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);
  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

// ===== rtl/ws3d_front.sv =====
// Front end: grid position tracking, window and delay RAMs, tap gathering
`include "assert_macros.svh"
module ws3d_front #(
  parameter int MAX_X = ws3d_pkg::DEF_MAX_X,
  parameter int MAX_Y = ws3d_pkg::DEF_MAX_Y,
  parameter int MAX_Z = ws3d_pkg::DEF_MAX_Z
) (
  input  logic                          clk,
  input  logic                          rst_n,
  ws3d_in_if.sink                       in_ch,
  input  logic [ws3d_pkg::SIZE_W-1:0]   size_x,
  input  logic [ws3d_pkg::SIZE_W-1:0]   size_y,
  input  logic [ws3d_pkg::SIZE_W-1:0]   size_z,
  input  logic                          size_wr,
  input  logic [$clog2(ws3d_pkg::QUEUE_DEPTH+1)-1:0] q_count,
  output logic                          push,
  output ws3d_pkg::ws3d_entry_t         entry
);
  localparam int WIN_DEPTH  = 4 * MAX_X * MAX_Y + 1;
  localparam int PREV_DEPTH = 2 * MAX_X * MAX_Y + 1;
  localparam int WAW   = $clog2(WIN_DEPTH);
  localparam int PAW   = $clog2(PREV_DEPTH);
  localparam int PL_W  = $clog2(MAX_X * MAX_Y + 1);
  localparam int POS_W = $clog2(MAX_X * MAX_Y * MAX_Z + 1);
  localparam int QD    = ws3d_pkg::QUEUE_DEPTH;
  localparam int QCW   = $clog2(QD + 1);
  localparam int SW    = ws3d_pkg::SIZE_W;
  localparam int NRT   = ws3d_pkg::N_RAM_TAPS;

  logic [1:0]       dcnt_r;
  logic [PL_W-1:0]  plane_r;
  logic [POS_W-1:0] total_r, lag_r;
  logic [PAW-1:0]   lagp_r;
  logic [WAW-1:0]   dist_r [NRT];

  logic [POS_W-1:0] in_pos_r, out_pos_r;
  logic [SW-1:0]    px_r, py_r, pz_r;
  logic [WAW-1:0]   wp_r;
  logic [PAW-1:0]   pp_r;

  logic acc, data_ok, do_step, res, eog, bnd;
  logic [15:0] wdat, pdat;
  logic [WAW-1:0] raddr [NRT];
  logic [PAW-1:0] praddr;
  logic [WAW:0]   wdiff [NRT];
  logic [PAW:0]   pdiff;
  logic [NRT-1:0][15:0] tap_q;
  logic [15:0] prev_q;
  logic v1_r, bnd1_r, eog1_r;
  logic [15:0] new1_r;
  logic [QCW:0] q_used;

  assign q_used      = {1'b0, q_count} + {{QCW{1'b0}}, v1_r};
  assign in_ch.ready = (dcnt_r == 2'd0) && !size_wr && (q_used < (QCW+1)'(QD));
  assign acc     = in_ch.valid && in_ch.ready;
  assign data_ok = in_pos_r < total_r;
  // a flush before the grid is complete is dropped
  assign do_step = acc && !(data_ok && in_ch.is_flush);
  assign res     = in_pos_r >= lag_r;
  assign eog     = out_pos_r == total_r - POS_W'(1);
  assign bnd     = (px_r < 7'd2) || (py_r < 7'd2) || (pz_r < 7'd2) ||
                   (px_r >= size_x - 7'd2) || (py_r >= size_y - 7'd2) ||
                   (pz_r >= size_z - 7'd2);
  assign wdat    = data_ok ? in_ch.cur_sample : 16'd0;
  assign pdat    = data_ok ? in_ch.prev_sample : 16'd0;

  // derived geometry, rebuilt after a size write: plane size first, then grid total, lag and tap distances
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= 2'd2;
    end else if (size_wr) begin
      dcnt_r <= 2'd2;
    end else if (dcnt_r != 2'd0) begin
      dcnt_r <= dcnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (dcnt_r == 2'd2) begin
      plane_r <= PL_W'(size_x) * PL_W'(size_y);
    end
    if (dcnt_r == 2'd1) begin
      total_r   <= POS_W'(plane_r) * POS_W'(size_z);
      lag_r     <= POS_W'(plane_r) << 1;
      lagp_r    <= PAW'(plane_r) << 1;
      dist_r[ws3d_pkg::TAP_ZM2] <= WAW'(plane_r) << 2;
      dist_r[ws3d_pkg::TAP_ZM1] <= (WAW'(plane_r) << 1) + WAW'(plane_r);
      dist_r[ws3d_pkg::TAP_YM2] <= (WAW'(plane_r) << 1) + (WAW'(size_x) << 1);
      dist_r[ws3d_pkg::TAP_YM1] <= (WAW'(plane_r) << 1) + WAW'(size_x);
      dist_r[ws3d_pkg::TAP_XM2] <= (WAW'(plane_r) << 1) + WAW'(2);
      dist_r[ws3d_pkg::TAP_XM1] <= (WAW'(plane_r) << 1) + WAW'(1);
      dist_r[ws3d_pkg::TAP_CEN] <= WAW'(plane_r) << 1;
      dist_r[ws3d_pkg::TAP_XP1] <= (WAW'(plane_r) << 1) - WAW'(1);
      dist_r[ws3d_pkg::TAP_XP2] <= (WAW'(plane_r) << 1) - WAW'(2);
      dist_r[ws3d_pkg::TAP_YP1] <= (WAW'(plane_r) << 1) - WAW'(size_x);
      dist_r[ws3d_pkg::TAP_YP2] <= (WAW'(plane_r) << 1) - (WAW'(size_x) << 1);
      dist_r[ws3d_pkg::TAP_ZP1] <= WAW'(plane_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || size_wr) begin
      in_pos_r <= '0; out_pos_r <= '0;
      px_r <= '0; py_r <= '0; pz_r <= '0;
      wp_r <= '0; pp_r <= '0;
    end else if (do_step) begin
      wp_r <= (wp_r == WAW'(WIN_DEPTH - 1)) ? '0 : wp_r + WAW'(1);
      pp_r <= (pp_r == PAW'(PREV_DEPTH - 1)) ? '0 : pp_r + PAW'(1);
      if (!res) begin
        in_pos_r <= in_pos_r + POS_W'(1);
      end else if (eog) begin
        in_pos_r <= '0; out_pos_r <= '0;
        px_r <= '0; py_r <= '0; pz_r <= '0;
        wp_r <= '0; pp_r <= '0;
      end else begin
        in_pos_r  <= in_pos_r + POS_W'(1);
        out_pos_r <= out_pos_r + POS_W'(1);
        if (px_r == size_x - 7'd1) begin
          px_r <= '0;
          if (py_r == size_y - 7'd1) begin
            py_r <= '0;
            pz_r <= pz_r + 7'd1;
          end else begin
            py_r <= py_r + 7'd1;
          end
        end else begin
          px_r <= px_r + 7'd1;
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NRT; k++) begin
      wdiff[k] = {1'b0, wp_r} - {1'b0, dist_r[k]};
      raddr[k] = wdiff[k][WAW] ? wdiff[k][WAW-1:0] + WAW'(WIN_DEPTH) : wdiff[k][WAW-1:0];
    end
    pdiff  = {1'b0, pp_r} - {1'b0, lagp_r};
    praddr = pdiff[PAW] ? pdiff[PAW-1:0] + PAW'(PREV_DEPTH) : pdiff[PAW-1:0];
  end

  for (genvar g = 0; g < NRT; g++) begin : g_win
    ws3d_ram #(.W(16), .DEPTH(WIN_DEPTH)) u_win (
      .clk(clk), .we(do_step), .waddr(wp_r), .wdata(wdat),
      .re(do_step && res), .raddr(raddr[g]), .rdata(tap_q[g])
    );
  end

  ws3d_ram #(.W(16), .DEPTH(PREV_DEPTH)) u_prev (
    .clk(clk), .we(do_step), .waddr(pp_r), .wdata(pdat),
    .re(do_step && res), .raddr(praddr), .rdata(prev_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= do_step && res;
  end

  always_ff @(posedge clk) begin
    if (do_step && res) begin
      new1_r <= wdat;
      bnd1_r <= bnd;
      eog1_r <= eog;
    end
  end

  assign push = v1_r;
  always_comb begin
    entry.taps[NRT-1:0]            = tap_q;
    entry.taps[ws3d_pkg::TAP_ZP2]  = new1_r;
    entry.prev                     = prev_q;
    entry.bnd                      = bnd1_r;
    entry.eog                      = eog1_r;
  end

  `WS3D_ASSERT(a_pos_lag, ((dcnt_r == 2'd0) && (in_pos_r >= lag_r)) |-> (in_pos_r == out_pos_r + lag_r))
  `WS3D_ASSERT(a_no_overflow, push |-> (q_count < QCW'(QD)))
  `WS3D_ASSERT_NEXT(a_eog_wrap, do_step && res && eog && !size_wr, (in_pos_r == '0) && (wp_r == '0))
endmodule

// ===== rtl/ws3d_queue.sv =====
// Short FIFO between the tap gatherer and the arithmetic back end
module ws3d_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [W-1:0]               din,
  input  logic                       pop,
  output logic [W-1:0]               dout,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int PW = $clog2(DEPTH);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [$clog2(DEPTH+1)-1:0] count_r;

  assign empty = count_r == '0;
  assign count = count_r;
  assign dout  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0; rd_r <= '0; count_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == LAST) ? '0 : wr_r + PW'(1);
      if (pop)  rd_r <= (rd_r == LAST) ? '0 : rd_r + PW'(1);
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= din;
  end
endmodule

// ===== rtl/ws3d_back.sv =====
// Back end: neighbour sums, coefficient products, rounding, saturation and zeroing at the boundary
module ws3d_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ws3d_pkg::ws3d_entry_t               entry,
  input  logic                                q_empty,
  output logic                                pop,
  input  logic signed [ws3d_pkg::COEF_W-1:0]  coef_centre,
  input  logic signed [ws3d_pkg::COEF_W-1:0]  coef_near,
  input  logic signed [ws3d_pkg::COEF_W-1:0]  coef_far,
  ws3d_out_if.source                          out_ch
);
  function automatic logic signed [18:0] sx19(logic [15:0] v);
    return {{3{v[15]}}, v};
  endfunction

  logic en;
  logic va_r, vb_r, vo_r;
  logic signed [18:0] s1_r, s2_r;
  logic signed [15:0] cen_r, prev_r;
  logic bnda_r, eoga_r, bndb_r, eogb_r;
  logic signed [39:0] m0_r, m1_r, m2_r, pq_r;
  logic signed [39:0] sum, rnd;
  logic signed [15:0] sat;
  logic [15:0] res_r;
  logic eog_r;

  assign en  = !vo_r || out_ch.ready;
  assign pop = en && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0; vb_r <= 1'b0; vo_r <= 1'b0;
    end else if (en) begin
      va_r <= pop; vb_r <= va_r; vo_r <= vb_r;
    end
  end

  always_comb begin
    sum = m0_r - pq_r + m1_r + m2_r + 40'sd32768;
    rnd = sum >>> 16;
    if (rnd > 40'sd32767)       sat = 16'sh7fff;
    else if (rnd < -40'sd32768) sat = -16'sh8000;
    else                        sat = rnd[15:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= sx19(entry.taps[ws3d_pkg::TAP_XM1]) + sx19(entry.taps[ws3d_pkg::TAP_XP1])
            + sx19(entry.taps[ws3d_pkg::TAP_YM1]) + sx19(entry.taps[ws3d_pkg::TAP_YP1])
            + sx19(entry.taps[ws3d_pkg::TAP_ZM1]) + sx19(entry.taps[ws3d_pkg::TAP_ZP1]);
      s2_r <= sx19(entry.taps[ws3d_pkg::TAP_XM2]) + sx19(entry.taps[ws3d_pkg::TAP_XP2])
            + sx19(entry.taps[ws3d_pkg::TAP_YM2]) + sx19(entry.taps[ws3d_pkg::TAP_YP2])
            + sx19(entry.taps[ws3d_pkg::TAP_ZM2]) + sx19(entry.taps[ws3d_pkg::TAP_ZP2]);
      cen_r  <= entry.taps[ws3d_pkg::TAP_CEN];
      prev_r <= entry.prev;
      bnda_r <= entry.bnd;
      eoga_r <= entry.eog;
      m0_r   <= 40'(coef_centre) * 40'(cen_r);
      m1_r   <= 40'(coef_near) * 40'(s1_r);
      m2_r   <= 40'(coef_far) * 40'(s2_r);
      pq_r   <= 40'(prev_r) <<< 16;
      bndb_r <= bnda_r;
      eogb_r <= eoga_r;
      res_r  <= bndb_r ? 16'd0 : sat;
      eog_r  <= eogb_r;
    end
  end

  assign out_ch.valid       = vo_r;
  assign out_ch.next_sample = res_r;
  assign out_ch.end_of_grid = eog_r;
endmodule

// ===== rtl/wave_stencil_3d_order4.sv =====
// Top level: one time step of the fourth-order 3D wave stencil
// Streams grid points in raster order (x fastest) and returns one result per
// point, lagging by two planes (2*size_x*size_y items); flush items drain the
// tail. Sustained rate is one item per cycle while the queue has room and
// out_ch accepts: twelve window RAM copies, each with one read port, supply
// the twelve stored taps of the 13-point window in the same cycle; tap 12 is
// the incoming sample. After a size write in_ch.ready is held low while the
// plane, grid and tap distances are recomputed. No clearing pass is run: taps
// not yet written in this grid feed only boundary points, whose result is 0.
module wave_stencil_3d_order4 #(
  parameter int MAX_X = ws3d_pkg::DEF_MAX_X,
  parameter int MAX_Y = ws3d_pkg::DEF_MAX_Y,
  parameter int MAX_Z = ws3d_pkg::DEF_MAX_Z
) (
  input  logic                              clk,
  input  logic                              rst_n,
  ws3d_in_if.sink                           in_ch,
  ws3d_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [ws3d_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ws3d_pkg::COEF_W-1:0]       cfg_data
);
  localparam int QD = ws3d_pkg::QUEUE_DEPTH;

  logic [ws3d_pkg::SIZE_W-1:0] size_x_r, size_y_r, size_z_r;
  logic signed [ws3d_pkg::COEF_W-1:0] coef_cen_r, coef_near_r, coef_far_r;
  logic size_wr;

  // size writes restart the grid
  assign size_wr = cfg_we && ((cfg_index == ws3d_pkg::REG_SIZE_X) ||
                              (cfg_index == ws3d_pkg::REG_SIZE_Y) ||
                              (cfg_index == ws3d_pkg::REG_SIZE_Z));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r    <= ws3d_pkg::clamp_size(ws3d_pkg::SIZE_RESET, MAX_X);
      size_y_r    <= ws3d_pkg::clamp_size(ws3d_pkg::SIZE_RESET, MAX_Y);
      size_z_r    <= ws3d_pkg::clamp_size(ws3d_pkg::SIZE_RESET, MAX_Z);
      coef_cen_r  <= ws3d_pkg::COEF_CEN_RESET;
      coef_near_r <= ws3d_pkg::COEF_NEAR_RESET;
      coef_far_r  <= ws3d_pkg::COEF_FAR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ws3d_pkg::REG_SIZE_X:    size_x_r <= ws3d_pkg::clamp_size(cfg_data[6:0], MAX_X);
        ws3d_pkg::REG_SIZE_Y:    size_y_r <= ws3d_pkg::clamp_size(cfg_data[6:0], MAX_Y);
        ws3d_pkg::REG_SIZE_Z:    size_z_r <= ws3d_pkg::clamp_size(cfg_data[6:0], MAX_Z);
        ws3d_pkg::REG_COEF_CEN:  coef_cen_r  <= cfg_data;
        ws3d_pkg::REG_COEF_NEAR: coef_near_r <= cfg_data;
        ws3d_pkg::REG_COEF_FAR:  coef_far_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // front -> queue -> back
  logic                          push, pop, q_empty;
  ws3d_pkg::ws3d_entry_t         f_entry, q_entry;
  logic [$clog2(QD+1)-1:0]       q_count;

  ws3d_front #(.MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z)) u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .size_x(size_x_r), .size_y(size_y_r), .size_z(size_z_r), .size_wr(size_wr),
    .q_count(q_count), .push(push), .entry(f_entry)
  );

  ws3d_queue #(.W($bits(ws3d_pkg::ws3d_entry_t)), .DEPTH(QD)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .din(f_entry),
    .pop(pop), .dout(q_entry), .empty(q_empty), .count(q_count)
  );

  ws3d_back u_back (
    .clk(clk), .rst_n(rst_n), .entry(q_entry), .q_empty(q_empty), .pop(pop),
    .coef_centre(coef_cen_r), .coef_near(coef_near_r), .coef_far(coef_far_r),
    .out_ch(out_ch)
  );
endmodule
